// ----- rtl/rc5_pkg.sv -----
package rc5_pkg;

  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 64;
  localparam int KEY_REGS       = 5;
  localparam int KEY_WORDS_HELD = 2 * KEY_REGS;
  localparam int KEY_LEN_W      = 6;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 3'd5;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET  = 6'd9;

  localparam logic [31:0] MAGIC_P = 32'hB7E15163;
  localparam logic [31:0] MAGIC_Q = 32'h9E3779B9;

  typedef struct packed {
    logic        kind;
    logic [31:0] word_a;
    logic [31:0] word_b;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_word_a;
    logic [31:0] out_word_b;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic exp_init;
    logic fill_step;
    logic mix_rd;
    logic mix_a;
    logic mix_b;
    logic run_prime;
    logic run_step;
    logic load_out;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic fill_last;
    logic mix_last;
    logic run_last;
  } dp_status_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] t;
    t = {x, x} << n;
    return t[63:32];
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] t;
    t = {x, x} >> n;
    return t[31:0];
  endfunction

endpackage

// ----- rtl/rc5_stream_if.sv -----
interface rc5_in_if;
  import rc5_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rc5_out_if;
  import rc5_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/rc5_block_cipher_core.sv -----
// Channel   Dir  Handshake        Payload
// in_ch     in   valid/ready      kind, word_a, word_b (one request = one block)
// out_ch    out  valid/ready      out_word_a, out_word_b
// cfg_*     in   cfg_we only      cfg_index, cfg_wdata (key bytes 0..39, key length)
//
// Result loaded after a prime step, one half-round per cycle (single read port of the
// subkey RAM) and an output load; a new request is taken only in idle, once the last
// result has moved into the output register.
// After reset or any key/length write the next request first runs the key schedule:
// max(2*(ROUNDS+1), MAX_KEY_WORDS) fill steps, then read, A and B steps per mixing iteration.
// Only control and key regs reset (length to 9); the schedule rewrites both RAMs before use.
// A stalled out_ch keeps one result in the output register and the next one in the core.
module rc5_block_cipher_core #(
  parameter int ROUNDS        = 12,
  parameter int MAX_KEY_WORDS = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rc5_in_if.sink                         in_ch,
  rc5_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [rc5_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rc5_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rc5_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;
  out_item_t  out_data;

  // sequencing: key schedule, half-round stepping, output hand-off
  rc5_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .status    (status),
    .cmd       (cmd)
  );

  // key registers, subkey/key-word RAMs, block words
  rc5_datapath #(
    .ROUNDS        (ROUNDS),
    .MAX_KEY_WORDS (MAX_KEY_WORDS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_ch.data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

endmodule

// ----- rtl/rc5_ram.sv -----
module rc5_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/rc5_ctrl.sv -----
module rc5_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  output logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           cfg_we,
  input  logic [rc5_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  rc5_pkg::dp_status_t            status,
  output rc5_pkg::ctrl_cmd_t             cmd
);
  import rc5_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_FILL   = 8'b0000_0010,
    ST_MIX_RD = 8'b0000_0100,
    ST_MIX_A  = 8'b0000_1000,
    ST_MIX_B  = 8'b0001_0000,
    ST_PRIME  = 8'b0010_0000,
    ST_RUN    = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   keys_ok_r, keys_ok_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc;
  logic   out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd.load_in = 1'b1;
          if (keys_ok_r) begin
            state_nxt = ST_PRIME;
          end else begin
            cmd.exp_init = 1'b1;
            state_nxt    = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (status.fill_last) state_nxt = ST_MIX_RD;
      end
      ST_MIX_RD: begin
        cmd.mix_rd = 1'b1;
        state_nxt  = ST_MIX_A;
      end
      ST_MIX_A: begin
        cmd.mix_a = 1'b1;
        state_nxt = ST_MIX_B;
      end
      ST_MIX_B: begin
        cmd.mix_b = 1'b1;
        state_nxt = status.mix_last ? ST_PRIME : ST_MIX_RD;
      end
      ST_PRIME: begin
        cmd.run_prime = 1'b1;
        state_nxt     = ST_RUN;
      end
      ST_RUN: begin
        cmd.run_step = 1'b1;
        if (status.run_last) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // any key or length write makes the subkeys stale
  always_comb begin
    keys_ok_nxt = keys_ok_r;
    if (cfg_we && (cfg_index <= REG_KEY_LENGTH)) begin
      keys_ok_nxt = 1'b0;
    end else if (cmd.mix_b && status.mix_last) begin
      keys_ok_nxt = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      keys_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      keys_ok_r   <= keys_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/rc5_datapath.sv -----
module rc5_datapath #(
  parameter int ROUNDS        = 12,
  parameter int MAX_KEY_WORDS = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rc5_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rc5_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  rc5_pkg::in_item_t              in_data,
  input  rc5_pkg::ctrl_cmd_t             cmd,
  output rc5_pkg::dp_status_t            status,
  output rc5_pkg::out_item_t             out_data
);
  import rc5_pkg::*;

  localparam int T      = 2 * (ROUNDS + 1);
  localparam int FILL_N = (T > MAX_KEY_WORDS) ? T : MAX_KEY_WORDS;
  localparam int FK_W   = $clog2(FILL_N + 1);
  localparam int A_W    = $clog2(T);
  localparam int J_W    = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
  localparam int LW     = $clog2(MAX_KEY_WORDS + 1);
  localparam int CAP    = 4 * MAX_KEY_WORDS;
  localparam int LEN_W  = ($clog2(CAP + 1) > KEY_LEN_W) ? $clog2(CAP + 1) : KEY_LEN_W;
  localparam int IT_W   = $clog2(3 * FILL_N);
  localparam int WX_W   = (FK_W > 4) ? FK_W : 4;

  // configuration
  logic [CFG_DATA_W-1:0] key_r [KEY_REGS];
  logic [KEY_LEN_W-1:0]  klen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < KEY_REGS; r++) key_r[r] <= '0;
      klen_r <= KEY_LEN_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_KEY_LENGTH) begin
        klen_r <= cfg_wdata[KEY_LEN_W-1:0];
      end
      for (int r = 0; r < KEY_REGS; r++) begin
        if (cfg_index == CFG_IDX_W'(r)) key_r[r] <= cfg_wdata;
      end
    end
  end

  // key length -> word count
  logic [LEN_W-1:0] klen_x, len_sat, wsum;
  logic [LW-1:0]    words;
  logic [FK_W-1:0]  len_q;
  logic [1:0]       len_part;

  always_comb begin
    klen_x   = LEN_W'(klen_r);
    len_sat  = (klen_x > LEN_W'(CAP)) ? LEN_W'(CAP) : klen_x;
    wsum     = len_sat + LEN_W'(3);
    words    = ((wsum >> 2) == '0) ? LW'(1) : LW'(wsum >> 2);
    len_q    = FK_W'(len_sat >> 2);
    len_part = len_sat[1:0];
  end

  // expansion counters
  logic [FK_W-1:0] fk_r;
  logic [31:0]     acc_r;
  logic [A_W-1:0]  i_r;
  logic [J_W-1:0]  j_r;
  logic [IT_W-1:0] it_r;
  logic [31:0]     ma_r, mb_r;
  logic [FK_W-1:0] mx;
  logic [IT_W-1:0] iters;

  always_comb begin
    mx    = (FK_W'(words) > FK_W'(T)) ? FK_W'(words) : FK_W'(T);
    iters = IT_W'({mx, 1'b0}) + IT_W'(mx);
  end

  // little-endian key word for fill position fk_r
  logic [31:0]     kw [KEY_WORDS_HELD];
  logic [WX_W-1:0] wx;
  logic [31:0]     kraw, kmask, key_word;

  always_comb begin
    for (int r = 0; r < KEY_REGS; r++) begin
      kw[2*r]   = key_r[r][31:0];
      kw[2*r+1] = key_r[r][63:32];
    end
    wx   = WX_W'(fk_r);
    kraw = (wx < WX_W'(KEY_WORDS_HELD)) ? kw[wx[3:0]] : 32'd0;
    if (fk_r < len_q) begin
      kmask = 32'hFFFF_FFFF;
    end else if (fk_r == len_q) begin
      case (len_part)
        2'd1:    kmask = 32'h0000_00FF;
        2'd2:    kmask = 32'h0000_FFFF;
        2'd3:    kmask = 32'h00FF_FFFF;
        default: kmask = 32'h0000_0000;
      endcase
    end else begin
      kmask = 32'h0000_0000;
    end
    key_word = kraw & kmask;
  end

  // RAMs
  logic           s_we, s_re, l_we, l_re;
  logic [A_W-1:0] s_waddr, s_raddr;
  logic [J_W-1:0] l_waddr, l_raddr;
  logic [31:0]    s_wdata, s_q, l_wdata, l_q;

  // block state
  logic           kind_r;
  logic [31:0]    a_r, b_r;
  logic [A_W-1:0] kaddr_r, kstart, knext;
  out_item_t      out_r;

  logic [31:0] mix_a_val, mix_b_val, ab;

  always_comb begin
    mix_a_val = rotl32(s_q + ma_r + mb_r, 5'd3);
    ab        = ma_r + mb_r;
    mix_b_val = rotl32(l_q + ab, ab[4:0]);
  end

  always_comb begin
    kstart = kind_r ? A_W'(T - 1) : '0;
    knext  = kind_r ? (kaddr_r - A_W'(1)) : (kaddr_r + A_W'(1));
  end

  always_comb begin
    s_we    = (cmd.fill_step && (fk_r < FK_W'(T))) || cmd.mix_a;
    s_waddr = cmd.mix_a ? i_r : fk_r[A_W-1:0];
    s_wdata = cmd.mix_a ? mix_a_val : acc_r;
    s_re    = cmd.mix_rd || cmd.run_prime || cmd.run_step;
    s_raddr = cmd.mix_rd ? i_r : (cmd.run_prime ? kstart : knext);
    l_we    = (cmd.fill_step && (fk_r < FK_W'(words))) || cmd.mix_b;
    l_waddr = cmd.mix_b ? j_r : fk_r[J_W-1:0];
    l_wdata = cmd.mix_b ? mix_b_val : key_word;
    l_re    = cmd.mix_rd;
    l_raddr = j_r;
  end

  rc5_ram #(.WIDTH(32), .DEPTH(T)) u_subkey_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_q)
  );

  rc5_ram #(.WIDTH(32), .DEPTH(MAX_KEY_WORDS)) u_keyword_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .re    (l_re),
    .raddr (l_raddr),
    .rdata (l_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.exp_init) begin
      fk_r  <= '0;
      acc_r <= MAGIC_P;
      i_r   <= '0;
      j_r   <= '0;
      it_r  <= '0;
      ma_r  <= '0;
      mb_r  <= '0;
    end else begin
      if (cmd.fill_step) begin
        fk_r  <= fk_r + FK_W'(1);
        acc_r <= acc_r + MAGIC_Q;
      end
      if (cmd.mix_a) begin
        ma_r <= mix_a_val;
      end
      if (cmd.mix_b) begin
        mb_r <= mix_b_val;
        i_r  <= (i_r == A_W'(T - 1)) ? '0 : (i_r + A_W'(1));
        j_r  <= (j_r == J_W'(words - LW'(1))) ? '0 : (j_r + J_W'(1));
        it_r <= it_r + IT_W'(1);
      end
    end
  end

  // one half-round per step; s_q holds the subkey at kaddr_r
  logic        first, odd;
  logic [31:0] a_step, b_step;

  always_comb begin
    first  = (kaddr_r < A_W'(2));
    odd    = kaddr_r[0];
    a_step = a_r;
    b_step = b_r;
    if (!kind_r) begin
      if (odd) begin
        b_step = first ? (b_r + s_q) : (rotl32(b_r ^ a_r, a_r[4:0]) + s_q);
      end else begin
        a_step = first ? (a_r + s_q) : (rotl32(a_r ^ b_r, b_r[4:0]) + s_q);
      end
    end else begin
      if (odd) begin
        b_step = first ? (b_r - s_q) : (rotr32(b_r - s_q, a_r[4:0]) ^ a_r);
      end else begin
        a_step = first ? (a_r - s_q) : (rotr32(a_r - s_q, b_r[4:0]) ^ b_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r <= in_data.kind;
      a_r    <= in_data.word_a;
      b_r    <= in_data.word_b;
    end else if (cmd.run_step) begin
      a_r <= a_step;
      b_r <= b_step;
    end
    if (cmd.run_prime) begin
      kaddr_r <= kstart;
    end else if (cmd.run_step) begin
      kaddr_r <= knext;
    end
    if (cmd.load_out) begin
      out_r.out_word_a <= a_r;
      out_r.out_word_b <= b_r;
    end
  end

  always_comb begin
    status.fill_last = (fk_r == FK_W'(FILL_N - 1));
    status.mix_last  = (it_r == (iters - IT_W'(1)));
    status.run_last  = kind_r ? (kaddr_r == '0) : (kaddr_r == A_W'(T - 1));
  end

  assign out_data = out_r;

endmodule

// ----- rtl/rc5_checker.sv -----
module rc5_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input rc5_pkg::out_item_t out_data
);
  import rc5_pkg::*;

  logic       in_acc, out_acc;
  logic [1:0] pend_r, pend_nxt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r + {1'b0, in_acc} - {1'b0, out_acc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without an outstanding request");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("request taken while the core is busy");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> pend_r <= 2'd1)
    else $error("more than two requests in flight");

endmodule

bind rc5_block_cipher_core rc5_checker u_rc5_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

// ----- dv/rc5_block_cipher_core_tb.sv -----
`timescale 1ns / 1ps

module rc5_block_cipher_core_tb;
  import rc5_pkg::*;

  localparam int ROUNDS          = 12;
  localparam int MAX_KEY_WORDS   = 10;
  localparam int TABLE_WORDS     = 2 * (ROUNDS + 1);
  localparam int RANDOM_PHASES   = 8;
  localparam int BLOCKS_PER_PHASE = 100;
  localparam int LONG_HOLD_AFTER = 300;   // results seen before the long output stall
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES     = 64;    // wait at the end for stray results
  localparam int CYCLE_LIMIT     = 400000;
  localparam int MAX_REPORTS     = 10;

  // register map: key bytes 0..39 in five 64-bit words, then the key length
  localparam logic [CFG_IDX_W-1:0] REG_KEY_0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_4    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;  // unmapped, write ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;  // unmapped, write ignored

  localparam logic KIND_ENC = 1'b0;
  localparam logic KIND_DEC = 1'b1;

  // one row of the directed table: either a register write or a request
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] wdata;
    in_item_t              blk;
    bit                    typed;   // want holds a hand-written result
    out_item_t             want;
  } drill_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rc5_in_if  in_ch();
  rc5_out_if out_ch();

  rc5_block_cipher_core #(
    .ROUNDS        (ROUNDS),
    .MAX_KEY_WORDS (MAX_KEY_WORDS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow of the key registers and the subkey table
  // ---------------------------------------------------------------------------
  logic [63:0] key_regs_shadow [KEY_REGS];
  logic [5:0]  key_len_shadow;
  logic [31:0] subkeys [TABLE_WORDS];
  bit          subkeys_fresh;

  out_item_t   cipher_results_due [$];   // blocks accepted, results not yet seen
  int unsigned mismatches;
  int unsigned results_seen;
  bit          idle_on;                  // both sides draw random gaps when set

  function automatic logic [31:0] rot_left(input logic [31:0] x, input logic [31:0] n);
    int unsigned s;
    s = n & 32'd31;
    if (s == 0) return x;   // published RC5 rotation: by zero leaves the word alone
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic logic [31:0] rot_right(input logic [31:0] x, input logic [31:0] n);
    int unsigned s;
    s = n & 32'd31;
    if (s == 0) return x;
    return (x >> s) | (x << (32 - s));
  endfunction

  // RC5 key schedule: pack key bytes LE into words, seed from P32/Q32, then mix
  function automatic void expand_subkeys();
    int unsigned len, words, iters, i, j;
    logic [31:0] kw [MAX_KEY_WORDS];
    logic [31:0] a, b;
    logic [7:0]  kb;
    len = key_len_shadow;
    if (len > 4 * MAX_KEY_WORDS) len = 4 * MAX_KEY_WORDS;   // over-long length saturates
    words = (len + 3) / 4;
    if (words == 0) words = 1;                              // zero length: one zero word
    foreach (kw[k]) kw[k] = '0;
    for (int k = 0; k < len; k++) begin
      kb = (k < 8 * KEY_REGS) ? key_regs_shadow[k / 8][8 * (k % 8) +: 8] : 8'h00;
      kw[k / 4] |= 32'(kb) << (8 * (k % 4));
    end
    subkeys[0] = MAGIC_P;
    for (int k = 1; k < TABLE_WORDS; k++) subkeys[k] = subkeys[k - 1] + MAGIC_Q;
    iters = 3 * ((TABLE_WORDS > words) ? TABLE_WORDS : words);
    i = 0;
    j = 0;
    a = '0;
    b = '0;
    for (int k = 0; k < iters; k++) begin
      subkeys[i] = rot_left(subkeys[i] + a + b, 3);
      a = subkeys[i];
      kw[j] = rot_left(kw[j] + a + b, a + b);
      b = kw[j];
      i = (i + 1) % TABLE_WORDS;
      j = (j + 1) % words;
    end
    subkeys_fresh = 1'b1;
  endfunction

  function automatic out_item_t cipher_block(input in_item_t blk);
    logic [31:0] a, b;
    out_item_t   res;
    if (!subkeys_fresh) expand_subkeys();
    a = blk.word_a;
    b = blk.word_b;
    if (blk.kind == KIND_ENC) begin
      a = a + subkeys[0];
      b = b + subkeys[1];
      for (int r = 1; r <= ROUNDS; r++) begin
        a = rot_left(a ^ b, b) + subkeys[2 * r];
        b = rot_left(b ^ a, a) + subkeys[2 * r + 1];
      end
    end else begin
      for (int r = ROUNDS; r >= 1; r--) begin
        b = rot_right(b - subkeys[2 * r + 1], a) ^ a;
        a = rot_right(a - subkeys[2 * r], b) ^ b;
      end
      a = a - subkeys[0];
      b = b - subkeys[1];
    end
    res.out_word_a = a;
    res.out_word_b = b;
    return res;
  endfunction

  function automatic void note_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
    if (idx < KEY_REGS) begin
      key_regs_shadow[idx] = val;
      subkeys_fresh = 1'b0;
    end else if (idx == REG_KEY_LENGTH) begin
      key_len_shadow = val[5:0];
      subkeys_fresh = 1'b0;
    end
    // unmapped index: nothing changes, table stays valid
  endfunction

  function automatic void report(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table helpers
  // ---------------------------------------------------------------------------
  function automatic drill_t ask(input logic kind, input logic [31:0] a, input logic [31:0] b);
    drill_t d;
    d = '{default: '0};
    d.blk = '{kind: kind, word_a: a, word_b: b};
    return d;
  endfunction

  function automatic drill_t ask_known(input logic kind, input logic [31:0] a,
                                       input logic [31:0] b, input logic [31:0] ea,
                                       input logic [31:0] eb);
    drill_t d;
    d = ask(kind, a, b);
    d.typed = 1'b1;
    d.want = '{out_word_a: ea, out_word_b: eb};
    return d;
  endfunction

  function automatic drill_t set_reg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] val);
    drill_t d;
    d = '{default: '0};
    d.is_cfg = 1'b1;
    d.idx = idx;
    d.wdata = val;
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving tasks
  // ---------------------------------------------------------------------------
  // leaves cfg_we high; the caller lowers it once the batch of writes is done
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    note_reg_write(idx, val);
    @(posedge clk);
  endtask

  // valid stays high on return so back-to-back requests need no extra step
  task automatic offer_block(input in_item_t blk);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= blk;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // called straight after an accepted request: drop valid and let the core empty
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (cipher_results_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_key_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // new key setting between phases; sometimes none, so a valid table gets reused
  task automatic randomise_key_setting();
    logic [63:0] len_word;
    case ($urandom_range(0, 5))
      0: ;
      1: write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, {$urandom, $urandom});
      default: begin
        for (int r = 0; r < KEY_REGS; r++)
          if ($urandom_range(0, 1)) write_reg(REG_KEY_0 + CFG_IDX_W'(r), pick_key_word());
        // upper bits of the length word are junk the core must mask off
        len_word = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'd0;
        case ($urandom_range(0, 5))
          0:       len_word[5:0] = 6'd0;
          1:       len_word[5:0] = 6'd40;
          2:       len_word[5:0] = 6'($urandom_range(41, 63));
          default: len_word[5:0] = 6'($urandom_range(1, 40));
        endcase
        write_reg(REG_KEY_LENGTH, len_word);
        if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE_HI, {$urandom, $urandom});
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready with random stalls, plus one long hold-off so the
  // core backs up and stops taking requests
  // ---------------------------------------------------------------------------
  initial begin : out_ready_drive
    int unsigned stall;
    bit          held_long;
    held_long = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 5) : 0;
      if (!held_long && results_seen >= LONG_HOLD_AFTER) begin
        stall = LONG_HOLD_CYCLES;
        held_long = 1'b1;
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (cipher_results_due.size() == 0) begin
        report($sformatf("result with nothing outstanding: a=%h b=%h",
                         out_ch.data.out_word_a, out_ch.data.out_word_b));
      end else begin
        want = cipher_results_due.pop_front();
        if (out_ch.data.out_word_a !== want.out_word_a)
          report($sformatf("out_word_a expected %h got %h",
                           want.out_word_a, out_ch.data.out_word_a));
        if (out_ch.data.out_word_b !== want.out_word_b)
          report($sformatf("out_word_b expected %h got %h",
                           want.out_word_b, out_ch.data.out_word_b));
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** rc5_block_cipher_core: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    drill_t    drills [$];
    in_item_t  blk;
    out_item_t got;
    out_item_t last_cipher;
    bit        have_cipher;
    bit        prev_cfg;

    foreach (key_regs_shadow[r]) key_regs_shadow[r] = '0;
    key_len_shadow = KEY_LEN_RESET;
    subkeys_fresh  = 1'b0;
    mismatches     = 0;
    results_seen   = 0;
    idle_on        = 1'b1;
    have_cipher    = 1'b0;
    last_cipher    = '0;

    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_wdata   <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Typed results: the published all-zero 16-byte key vector
    // and its inverse; an unmapped write must leave that result unchanged.
    drills = '{
      // reset key: all-zero bytes, length 9
      ask(KIND_ENC, 32'h0000_0000, 32'h0000_0000),
      ask(KIND_ENC, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
      ask(KIND_DEC, 32'h0000_0000, 32'h0000_0000),
      ask(KIND_DEC, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
      ask(KIND_ENC, 32'h8000_0000, 32'h0000_0001),
      ask(KIND_DEC, 32'h0000_0001, 32'h8000_0000),
      set_reg(REG_KEY_LENGTH, 64'd16),
      ask_known(KIND_ENC, 32'h0000_0000, 32'h0000_0000, 32'hEEDB_A521, 32'h6D8F_4B15),
      ask_known(KIND_DEC, 32'hEEDB_A521, 32'h6D8F_4B15, 32'h0000_0000, 32'h0000_0000),
      set_reg(REG_SPARE_LO, 64'hFFFF_FFFF_FFFF_FFFF),
      ask_known(KIND_ENC, 32'h0000_0000, 32'h0000_0000, 32'hEEDB_A521, 32'h6D8F_4B15),
      set_reg(REG_SPARE_HI, 64'h0123_4567_89AB_CDEF),
      ask_known(KIND_DEC, 32'hEEDB_A521, 32'h6D8F_4B15, 32'h0000_0000, 32'h0000_0000),
      // zero key length: one zero key word
      set_reg(REG_KEY_LENGTH, 64'd0),
      ask(KIND_ENC, 32'h0000_0000, 32'h0000_0000),
      ask(KIND_DEC, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
      ask(KIND_ENC, 32'hA5A5_A5A5, 32'h5A5A_5A5A),
      // full 40-byte key of ones
      set_reg(REG_KEY_0, 64'hFFFF_FFFF_FFFF_FFFF),
      set_reg(REG_KEY_1, 64'hFFFF_FFFF_FFFF_FFFF),
      set_reg(REG_KEY_2, 64'hFFFF_FFFF_FFFF_FFFF),
      set_reg(REG_KEY_3, 64'hFFFF_FFFF_FFFF_FFFF),
      set_reg(REG_KEY_4, 64'hFFFF_FFFF_FFFF_FFFF),
      set_reg(REG_KEY_LENGTH, 64'd40),
      ask(KIND_ENC, 32'h0000_0000, 32'h0000_0000),
      ask(KIND_DEC, 32'h0000_0000, 32'h0000_0000),
      ask(KIND_ENC, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
      // length past 40 saturates; junk above bit 5 is masked
      set_reg(REG_KEY_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF),
      ask(KIND_ENC, 32'h0000_0000, 32'h0000_0000),
      ask(KIND_DEC, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
      // single byte, then a part-filled second word
      set_reg(REG_KEY_0, 64'h0123_4567_89AB_CDEF),
      set_reg(REG_KEY_2, 64'hDEAD_BEEF_CAFE_F00D),
      set_reg(REG_KEY_LENGTH, 64'd1),
      ask(KIND_ENC, 32'h1234_5678, 32'h9ABC_DEF0),
      ask(KIND_DEC, 32'h1234_5678, 32'h9ABC_DEF0),
      set_reg(REG_KEY_LENGTH, 64'd5),
      ask(KIND_ENC, 32'h1234_5678, 32'h9ABC_DEF0),
      ask(KIND_DEC, 32'h1234_5678, 32'h9ABC_DEF0)
    };

    prev_cfg = 1'b0;
    foreach (drills[n]) begin
      if (drills[n].is_cfg) begin
        if (!prev_cfg) wait_idle();     // registers only change with the core empty
        write_reg(drills[n].idx, drills[n].wdata);
        prev_cfg = 1'b1;
      end else begin
        if (prev_cfg) cfg_we <= 1'b0;
        offer_block(drills[n].blk);
        got = cipher_block(drills[n].blk);   // keeps the shadow table in step
        cipher_results_due.push_back(drills[n].typed ? drills[n].want : got);
        prev_cfg = 1'b0;
      end
    end
    wait_idle();

    // Random phases: new key setting, then a run of requests. Some decrypts
    // take back an earlier ciphertext so round trips get exercised too.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      randomise_key_setting();
      cfg_we <= 1'b0;
      for (int n = 0; n < BLOCKS_PER_PHASE; n++) begin
        blk.kind   = $urandom_range(0, 1) ? KIND_DEC : KIND_ENC;
        blk.word_a = pick_word();
        blk.word_b = pick_word();
        if (blk.kind == KIND_DEC && have_cipher && $urandom_range(0, 2) == 0) begin
          blk.word_a = last_cipher.out_word_a;
          blk.word_b = last_cipher.out_word_b;
        end
        offer_block(blk);
        got = cipher_block(blk);
        cipher_results_due.push_back(got);
        if (blk.kind == KIND_ENC) begin
          last_cipher = got;
          have_cipher = 1'b1;
        end
      end
      wait_idle();
    end

    // anything stray would show up during the tail wait
    repeat (TAIL_CYCLES) @(posedge clk);
    if (cipher_results_due.size() != 0)
      report($sformatf("%0d results never arrived", cipher_results_due.size()));

    if (mismatches == 0)
      $display("** rc5_block_cipher_core: PASSED **");
    else
      $display("** rc5_block_cipher_core: FAILED **");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rc5_pkg.sv
rtl/rc5_stream_if.sv
rtl/rc5_ram.sv
rtl/rc5_ctrl.sv
rtl/rc5_datapath.sv
rtl/rc5_block_cipher_core.sv
rtl/rc5_checker.sv
dv/rc5_block_cipher_core_tb.sv
